>>> sv/patd_pkg.sv
package patd_pkg;

    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned PULSE_W  = 8;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 8'd3;

    localparam logic [DELAY_W-1:0] RST_STEP_TICKS  = 16'd1000;
    localparam logic [DELAY_W-1:0] RST_MIN_DELAY   = 16'd1000;
    localparam logic [DELAY_W-1:0] RST_MAX_DELAY   = 16'd8000;
    localparam logic [PULSE_W-1:0] RST_PULSE_WIDTH = 8'd50;

    typedef struct packed {
        logic [DELAY_W-1:0] step_ticks;
        logic [DELAY_W-1:0] min_delay;
        logic [DELAY_W-1:0] max_delay;
        logic [PULSE_W-1:0] pulse_width;
    } cfg_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_ticks;
        logic [DELAY_W-1:0] countdown;
        logic               armed;
        logic [PULSE_W-1:0] pulse_left;
        logic               last_sync;
    } tick_state_t;

    typedef struct packed {
        logic sync_level;
        logic up_press;
        logic down_press;
    } tick_in_t;

    // trigger in bit 0, delay_now above it
    typedef struct packed {
        logic [DELAY_W-1:0] delay_now;
        logic               trigger;
    } result_t;

endpackage

>>> sv/patd_tick.sv
module patd_tick (
    input  patd_pkg::cfg_t        cfg,
    input  patd_pkg::tick_state_t cur,
    input  patd_pkg::tick_in_t    tick,
    output patd_pkg::tick_state_t nxt,
    output patd_pkg::result_t     res
);

    logic                          edge_seen;
    logic [patd_pkg::PULSE_W-1:0]  pulse_mid;
    logic [patd_pkg::DELAY_W:0]    up_sum;
    logic [patd_pkg::DELAY_W-1:0]  delay_up;
    logic [patd_pkg::DELAY_W-1:0]  delay_dn;

    assign edge_seen = tick.sync_level != cur.last_sync;

    always_comb
    begin
        nxt           = cur;
        nxt.last_sync = tick.sync_level;
        pulse_mid     = cur.pulse_left;
        if (edge_seen)
        begin
            nxt.countdown = cur.delay_ticks;
            nxt.armed     = 1'b1;
        end
        else if (cur.armed)
        begin
            if (cur.countdown == '0)
            begin
                nxt.armed = 1'b0;
                pulse_mid = cfg.pulse_width;
            end
            else
            begin
                nxt.countdown = cur.countdown - 1'b1;
            end
        end

        res.trigger    = pulse_mid != '0;
        nxt.pulse_left = res.trigger ? pulse_mid - 1'b1 : pulse_mid;

        // up first, saturating at the maximum
        up_sum = {1'b0, cur.delay_ticks} + {1'b0, cfg.step_ticks};
        if (!tick.up_press)
            delay_up = cur.delay_ticks;
        else if (cur.delay_ticks >= cfg.max_delay)
            delay_up = cfg.max_delay;
        else if (up_sum > {1'b0, cfg.max_delay})
            delay_up = cfg.max_delay;
        else
            delay_up = up_sum[patd_pkg::DELAY_W-1:0];

        // then down, saturating at the minimum with no wrap below zero
        if (!tick.down_press)
            delay_dn = delay_up;
        else if (delay_up <= cfg.min_delay)
            delay_dn = cfg.min_delay;
        else if (cfg.step_ticks > delay_up || (delay_up - cfg.step_ticks) < cfg.min_delay)
            delay_dn = cfg.min_delay;
        else
            delay_dn = delay_up - cfg.step_ticks;

        nxt.delay_ticks = delay_dn;
        res.delay_now   = delay_dn;
    end

endmodule

>>> sv/patd_out_buf.sv
module patd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  patd_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output patd_pkg::result_t out_data
);

    logic              main_valid_reg;
    logic              main_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    patd_pkg::result_t main_reg;
    patd_pkg::result_t main_next;
    patd_pkg::result_t skid_reg;
    patd_pkg::result_t skid_next;
    logic              take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign take      = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!main_valid_reg || take)
            begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

>>> sv/phase_angle_trigger_delay_core.sv
// Phase-angle trigger delay for a triac dimmer. Each input beat is one timer
// tick carrying the mains sync level and the up and down button events; each
// tick gives exactly one result beat with the trigger level and the current
// delay. A sync level change in either direction loads a countdown with the
// delay; the trigger goes high on the delay+1'th tick after that change (with
// no further change between) and stays high for pulse_width ticks.
// The buttons move the delay by step_ticks within [min_delay, max_delay],
// up applied before down. The state update is a single pass of logic between
// the state registers and the result register, so one beat is accepted every
// clock unless the output buffer is full. A two-entry buffer keeps input
// flowing while a result waits; input stalls only once both entries are full.
// Configuration (index 0 step_ticks, 1 min_delay, 2 max_delay, 3 pulse_width)
// is written over its own channel, always ready, and must be written idle.
module phase_angle_trigger_delay_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // tick input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] sync_level, [1] up_press, [2] down_press, [7:3] zero
    input  logic [patd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] trigger, [16:1] delay_now, [23:17] zero
    output logic [patd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [patd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [patd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    patd_pkg::cfg_t        cfg_reg;
    patd_pkg::tick_state_t state_reg;
    patd_pkg::tick_state_t state_next;
    patd_pkg::tick_in_t    tick;
    patd_pkg::result_t     res;
    patd_pkg::result_t     res_out;
    logic                  s_accept;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_axis_tvalid && s_axis_tready;

    assign tick.sync_level = s_axis_tdata[0];
    assign tick.up_press   = s_axis_tdata[1];
    assign tick.down_press = s_axis_tdata[2];

    // configuration registers; out-of-range indexes drop silently
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ticks  <= patd_pkg::RST_STEP_TICKS;
            cfg_reg.min_delay   <= patd_pkg::RST_MIN_DELAY;
            cfg_reg.max_delay   <= patd_pkg::RST_MAX_DELAY;
            cfg_reg.pulse_width <= patd_pkg::RST_PULSE_WIDTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                patd_pkg::REG_STEP_TICKS:  cfg_reg.step_ticks  <= cfg_data;
                patd_pkg::REG_MIN_DELAY:   cfg_reg.min_delay   <= cfg_data;
                patd_pkg::REG_MAX_DELAY:   cfg_reg.max_delay   <= cfg_data;
                patd_pkg::REG_PULSE_WIDTH:
                    cfg_reg.pulse_width <= cfg_data[patd_pkg::PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // one tick of timing logic
    patd_tick u_tick (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .tick (tick),
        .nxt  (state_next),
        .res  (res)
    );

    // advance state only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.delay_ticks <= patd_pkg::RST_MAX_DELAY;
            state_reg.countdown   <= '0;
            state_reg.armed       <= 1'b0;
            state_reg.pulse_left  <= '0;
            state_reg.last_sync   <= 1'b0;
        end
        else if (s_accept)
        begin
            state_reg <= state_next;
        end
    end

    // hold results until the sink takes them
    patd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res_out)
    );

    assign m_axis_tdata = {{(patd_pkg::M_TDATA_W - $bits(patd_pkg::result_t)){1'b0}}, res_out};

    // a stalled input means both buffer entries hold results
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // a sync change always arms the countdown
    a_edge_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_axis_tdata[0] != state_reg.last_sync)) |=> state_reg.armed)
        else $error("sync edge did not arm countdown");

    // no button, no change to the delay
    a_delay_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !s_axis_tdata[1] && !s_axis_tdata[2]) |=> $stable(state_reg.delay_ticks))
        else $error("delay moved without a button event");

    // every accepted beat leaves a result pending
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

endmodule
